>>> design/bna_pkg.sv
`timescale 1ns / 1ps

package bna_pkg;

   // request field widths
   localparam int OP_W    = 2;
   localparam int NODE_W  = 7;
   localparam int BYTE_W  = 8;

   // result field widths
   localparam int STAT_W  = 2;
   localparam int OUT_W   = 7;

   // nodes per priority-encoder group, and the width of a bit position in a group
   localparam int GROUP_BITS = 8;
   localparam int GROUP_W    = 3;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [NODE_W-1:0] node_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [STAT_W-1:0] status_type;
   typedef logic [OUT_W-1:0]  count_type;

   // request codes
   localparam op_type OP_ALLOC   = 2'd0;
   localparam op_type OP_RELEASE = 2'd1;
   localparam op_type OP_CLEAR   = 2'd2;
   localparam op_type OP_MARK    = 2'd3;

   // status codes
   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

endpackage

>>> design/bitmap_node_allocator.sv
`timescale 1ns / 1ps

// channel   | ports                                       | direction
// ----------+---------------------------------------------+----------
// request   | req_valid req_ready req_op req_node         | in
//           | req_valid_byte                              |
// response  | rsp_valid rsp_ready rsp_status rsp_granted  | out
//           | rsp_free_count                              |
//
// one item per cycle sustained while results are taken; each item passes
// through the input register and then the result register
// the map is read, searched and updated as an item moves from the input
// register to the result register, so the next item always sees the new map
// the lowest free node comes from a two-level encoder: a lowest-bit pick in
// each 8-node group, then a pick of the first group with a free node
// synchronous reset frees every node and loads the free count with NODE_COUNT
// a stalled response holds the result register; the input register still
// takes an item, if it is empty, while the held one waits

module bitmap_node_allocator #(
   parameter int NODE_COUNT = 96
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  bna_pkg::op_type     req_op,
   input  bna_pkg::node_type   req_node,
   input  bna_pkg::byte_type   req_valid_byte,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bna_pkg::status_type rsp_status,
   output bna_pkg::count_type  rsp_granted,
   output bna_pkg::count_type  rsp_free_count
);

   import bna_pkg::*;

   localparam int GROUPS = (NODE_COUNT + GROUP_BITS - 1) / GROUP_BITS;
   localparam int PAD_W  = GROUPS * GROUP_BITS;
   localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int POS_W  = GRP_W + GROUP_W;
   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int CNT_W  = $clog2(NODE_COUNT + 1);

   // input register
   logic     in_vld_ff;
   op_type   op_ff;
   node_type node_ff;
   byte_type vbyte_ff;

   // result register
   logic       rsp_vld_ff;
   status_type status_ff, status_in;
   count_type  granted_ff, granted_in;
   count_type  free_out_ff, free_out_in;

   // allocator state
   logic [NODE_COUNT-1:0] used_ff, used_in;
   logic [CNT_W-1:0]      free_ff, free_in;

   logic advance;

   // lowest-free search
   logic [PAD_W-1:0]   free_pad;
   logic [GROUPS-1:0]  grp_any;
   logic [GROUP_W-1:0] grp_low [GROUPS];
   logic [GRP_W-1:0]   sel_grp;
   logic               found;
   logic [POS_W-1:0]   alloc_pos;

   // named-node decode
   logic             node_bad;
   logic [IDX_W-1:0] node_idx;
   logic             was_used;
   logic             want_used;

   // the input register drains whenever the result register is empty or taken
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   // free bits padded with used entries past the last node
   always_comb begin
      free_pad = '0;
      free_pad[NODE_COUNT-1:0] = ~used_ff;
   end

   // lowest free bit of each group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any[g] = |free_pad[g*GROUP_BITS +: GROUP_BITS];
         grp_low[g] = '0;
         for (int b = GROUP_BITS - 1; b >= 0; b--) begin
            if (free_pad[g*GROUP_BITS + b]) begin
               grp_low[g] = GROUP_W'(b);
            end
         end
      end
   end

   // first group holding a free node
   always_comb begin
      sel_grp = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            sel_grp = GRP_W'(g);
         end
      end
      found     = |grp_any;
      alloc_pos = {sel_grp, grp_low[sel_grp]};
   end

   // release and mark only take nodes 1 to NODE_COUNT
   assign node_bad  = (node_ff == '0) || (32'(node_ff) > NODE_COUNT);
   assign node_idx  = IDX_W'(node_ff - NODE_W'(1));
   assign was_used  = used_ff[node_idx];
   assign want_used = (op_ff == OP_MARK) ? (|vbyte_ff) : 1'b0;

   // request execution
   always_comb begin
      used_in    = used_ff;
      free_in    = free_ff;
      status_in  = ST_DONE;
      granted_in = '0;

      case (op_ff)
         OP_ALLOC: begin
            if (found) begin
               used_in[IDX_W'(alloc_pos)] = 1'b1;
               if (free_ff != '0) begin
                  free_in = free_ff - CNT_W'(1);
               end
               granted_in = OUT_W'({1'b0, alloc_pos} + (POS_W + 1)'(1));
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_CLEAR: begin
            used_in = '0;
            free_in = CNT_W'(NODE_COUNT);
         end
         OP_RELEASE, OP_MARK: begin
            if (node_bad) begin
               status_in = ST_RANGE;
            end else if (was_used != want_used) begin
               used_in[node_idx] = want_used;
               if (want_used) begin
                  if (free_ff != '0) begin
                     free_in = free_ff - CNT_W'(1);
                  end
               end else if (free_ff != CNT_W'(NODE_COUNT)) begin
                  free_in = free_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase

      free_out_in = OUT_W'(free_in);
   end

   // control and map state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         used_ff    <= '0;
         free_ff    <= CNT_W'(NODE_COUNT);
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
            used_ff    <= used_in;
            free_ff    <= free_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= req_op;
         node_ff  <= req_node;
         vbyte_ff <= req_valid_byte;
      end
      if (advance) begin
         status_ff   <= status_in;
         granted_ff  <= granted_in;
         free_out_ff <= free_out_in;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_status     = status_ff;
   assign rsp_granted    = granted_ff;
   assign rsp_free_count = free_out_ff;

   // running free count always matches the map
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      (32'($countones(used_ff)) + 32'(free_ff)) == NODE_COUNT)
      else $error("free count out of step with used map");

   // a full report only comes from an empty free count
   a_full_means_empty: assert property (@(posedge clock) disable iff (reset)
      advance && (status_in == ST_FULL) |-> (free_ff == '0))
      else $error("map reported full with free nodes left");

   // a grant always takes exactly one node
   a_grant_takes_one: assert property (@(posedge clock) disable iff (reset)
      advance && (granted_in != '0) |=> (free_ff == $past(free_ff) - CNT_W'(1)))
      else $error("grant did not lower free count by one");

   // nothing changes the map without an item moving on
   a_map_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(used_ff) && $stable(free_ff))
      else $error("map changed with no item in flight");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import bna_pkg::*;

   localparam int NODES        = 96;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 200000;
   // two register stages from accept to result, plus margin
   localparam int SETTLE       = 8;

   // one result item as the block reports it
   typedef struct packed {
      status_type status;
      count_type  granted;
      count_type  free_count;
   } result_type;

   // one row of the directed script; typed rows carry a hand-written answer
   typedef struct packed {
      op_type     op;
      node_type   node;
      byte_type   vb;
      bit         typed;
      result_type want;
   } script_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   op_type     req_op;
   node_type   req_node;
   byte_type   req_valid_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   status_type rsp_status;
   count_type  rsp_granted;
   count_type  rsp_free_count;

   // shadow of the allocation map, node numbers 1-based
   bit             used_map [1:NODES];
   int             free_nodes;
   result_type     owed_results [$];
   script_row_type script [$];

   int errors;
   int cycles;
   int sent_count;
   int burst_left;
   bit hold_done;

   bitmap_node_allocator #(.NODE_COUNT(NODES)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_node       (req_node),
      .req_valid_byte (req_valid_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_granted    (rsp_granted),
      .rsp_free_count (rsp_free_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   // apply one request to the shadow map and return what the block should say
   function automatic result_type map_update(op_type op, node_type node, byte_type vb);
      result_type r;
      bit         want;
      r.status  = ST_DONE;
      r.granted = '0;
      case (op)
         OP_ALLOC: begin
            // lowest free node wins; none free means the map is full
            r.status = ST_FULL;
            for (int i = 1; i <= NODES && r.status == ST_FULL; i++) begin
               if (!used_map[i]) begin
                  used_map[i] = 1'b1;
                  free_nodes--;
                  r.granted = count_type'(i);
                  r.status  = ST_DONE;
               end
            end
         end
         OP_CLEAR: begin
            foreach (used_map[i]) used_map[i] = 1'b0;
            free_nodes = NODES;
         end
         default: begin
            if (node == 0 || node > NODES) begin
               // node number outside the map, nothing changes
               r.status = ST_RANGE;
            end else begin
               // release always frees, mark follows the valid byte
               want = (op == OP_MARK) && (vb != 0);
               if (used_map[node] != want) begin
                  used_map[node] = want;
                  free_nodes += want ? -1 : 1;
               end
            end
         end
      endcase
      r.free_count = count_type'(free_nodes);
      return r;
   endfunction

   // offer one item, hold it until accepted, then maybe open a gap
   task automatic issue(op_type op, node_type node, byte_type vb, bit typed,
                        result_type typed_r);
      result_type r;
      int         gap;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_op         <= op;
      req_node       <= node;
      req_valid_byte <= vb;
      do @(posedge clock); while (!req_ready);
      r = map_update(op, node, vb);
      owed_results.push_back(typed ? typed_r : r);
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // end of burst: drop valid for a gap of random length
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   // lower valid and wait until every owed result has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(op_type op, node_type node, byte_type vb, bit typed = 1'b0,
                          status_type st = ST_DONE, count_type gr = '0, count_type fc = '0);
      script_row_type row;
      row.op              = op;
      row.node            = node;
      row.vb              = vb;
      row.typed           = typed;
      row.want.status     = st;
      row.want.granted    = gr;
      row.want.free_count = fc;
      script.push_back(row);
   endtask

   // zero about a third of the time so marks free nodes as well as claim them
   function automatic byte_type pick_byte();
      return ($urandom_range(0, 2) == 0) ? 8'h00 : byte_type'($urandom_range(1, 255));
   endfunction

   function automatic node_type bad_node();
      return ($urandom_range(0, 3) == 0) ? node_type'(0)
                                         : node_type'($urandom_range(NODES + 1, 127));
   endfunction

   // one random sequence; most kinds are well-formed use of the map
   task automatic random_sequence();
      int kind;
      int n;
      int k;
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
         // fill run of up to 110 allocations, which can run the map full from empty
         n = $urandom_range(10, 110);
         repeat (n) issue(OP_ALLOC, node_type'($urandom), byte_type'($urandom), 1'b0, '0);
      end else if (kind <= 5) begin
         // churn: allocate, release and mark inside the map
         n = $urandom_range(10, 40);
         repeat (n) begin
            k = $urandom_range(0, 9);
            if (k < 4)
               issue(OP_ALLOC, node_type'($urandom), byte_type'($urandom), 1'b0, '0);
            else if (k < 8)
               issue(OP_RELEASE, node_type'($urandom_range(1, NODES)), byte_type'($urandom),
                     1'b0, '0);
            else
               issue(OP_MARK, node_type'($urandom_range(1, NODES)), pick_byte(), 1'b0, '0);
         end
      end else if (kind <= 7) begin
         // rebuild: clear, mark nodes in order from random bytes, then allocate
         issue(OP_CLEAR, node_type'($urandom), byte_type'($urandom), 1'b0, '0);
         n = $urandom_range(8, NODES);
         for (k = 1; k <= n; k++) issue(OP_MARK, node_type'(k), pick_byte(), 1'b0, '0);
         repeat ($urandom_range(1, 6))
            issue(OP_ALLOC, node_type'($urandom), byte_type'($urandom), 1'b0, '0);
      end else if (kind == 8) begin
         // noise: any field value at all
         n = $urandom_range(5, 20);
         repeat (n) issue(op_type'($urandom), node_type'($urandom), byte_type'($urandom), 1'b0, '0);
      end else begin
         // out-of-range node numbers on release and mark
         n = $urandom_range(3, 10);
         repeat (n)
            issue($urandom_range(0, 1) ? OP_RELEASE : OP_MARK, bad_node(), byte_type'($urandom),
                  1'b0, '0);
      end
   endtask

   // result side: compare each accepted item with the oldest owed result
   always @(posedge clock) begin
      result_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("result with none owed: status %0d granted %0d free %0d",
                                      rsp_status, rsp_granted, rsp_free_count));
         end else begin
            head = owed_results.pop_front();
            if (rsp_status !== head.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, head.status));
            if (rsp_granted !== head.granted)
               report_mismatch($sformatf("granted %0d, expected %0d", rsp_granted, head.granted));
            if (rsp_free_count !== head.free_count)
               report_mismatch($sformatf("free_count %0d, expected %0d",
                                         rsp_free_count, head.free_count));
         end
      end
   end

   // receiver: stall pattern in stretches, plus one long hold-off that backs
   // the block up into its input
   initial begin
      int hold_left;
      int mode;
      int mode_left;
      int phase;
      hold_left = 0;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && sent_count >= 150) begin
            hold_done = 1'b1;
            hold_left = 80;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 99) >= 35);
               default: rsp_ready <= (phase % 3 == 0);
            endcase
         end
      end
   end

   // sender and run control
   initial begin
      bit paused;
      errors         = 0;
      cycles         = 0;
      sent_count     = 0;
      burst_left     = 0;
      hold_done      = 1'b0;
      paused         = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_ALLOC;
      req_node       = '0;
      req_valid_byte = '0;
      foreach (used_map[i]) used_map[i] = 1'b0;
      free_nodes = NODES;

      // directed script; hand answers only where they are plain
      add_row(OP_ALLOC,   7'd0,   8'h00, 1'b1, ST_DONE,  7'd1, 7'd95);
      add_row(OP_ALLOC,   7'd127, 8'hFF, 1'b1, ST_DONE,  7'd2, 7'd94);
      add_row(OP_RELEASE, 7'd0,   8'h00, 1'b1, ST_RANGE, 7'd0, 7'd94);
      add_row(OP_RELEASE, 7'd97,  8'h00, 1'b1, ST_RANGE, 7'd0, 7'd94);
      add_row(OP_MARK,    7'd127, 8'hFF, 1'b1, ST_RANGE, 7'd0, 7'd94);
      add_row(OP_MARK,    7'd96,  8'h80);
      add_row(OP_ALLOC,   7'd5,   8'h00);
      add_row(OP_RELEASE, 7'd1,   8'h00);
      // releasing a node that is already free
      add_row(OP_RELEASE, 7'd1,   8'hFF);
      add_row(OP_ALLOC,   7'd0,   8'h00);
      // mark that matches the bit already there
      add_row(OP_MARK,    7'd2,   8'h01);
      add_row(OP_MARK,    7'd2,   8'h00);
      add_row(OP_MARK,    7'd5,   8'h00);
      add_row(OP_MARK,    7'd1,   8'hFF);
      add_row(OP_MARK,    7'd95,  8'h55);
      add_row(OP_MARK,    7'd64,  8'hAA);
      add_row(OP_RELEASE, 7'd96,  8'h00);
      add_row(OP_CLEAR,   7'd127, 8'hFF, 1'b1, ST_DONE,  7'd0, 7'd96);
      add_row(OP_MARK,    7'd96,  8'h00);
      add_row(OP_ALLOC,   7'd0,   8'h00, 1'b1, ST_DONE,  7'd1, 7'd95);
      add_row(OP_RELEASE, 7'd127, 8'hFF, 1'b1, ST_RANGE, 7'd0, 7'd95);
      add_row(OP_MARK,    7'd0,   8'h00, 1'b1, ST_RANGE, 7'd0, 7'd95);
      add_row(OP_CLEAR,   7'd0,   8'h00, 1'b1, ST_DONE,  7'd0, 7'd96);
      add_row(OP_RELEASE, 7'd96,  8'h00);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         issue(script[i].op, script[i].node, script[i].vb, script[i].typed, script[i].want);
      drain();

      // random part; one full pause partway through
      while (sent_count < script.size() + RANDOM_ITEMS) begin
         random_sequence();
         if (!paused && sent_count >= 300) begin
            paused = 1'b1;
            drain();
         end
      end
      drain();
      repeat (SETTLE) @(posedge clock);

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
